### sv/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 shared package
// S-box tables, round constants, round and key schedule functions, and the
// control and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int BLOCK_W   = 128;
    localparam int HALF_W    = 64;
    localparam int RK_DEPTH  = 11;
    localparam int RK_AW     = $clog2(RK_DEPTH);
    localparam int CFG_IDX_W = 2;

    localparam logic [RK_AW-1:0] LAST_ROUND = RK_AW'(RK_DEPTH - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_UPPER = 2'd0,
        CFG_KEY_LOWER = 2'd1,
        CFG_DIRECTION = 2'd2
    } cfg_index_t;

    typedef enum logic {
        DIR_ENCRYPT = 1'b0,
        DIR_DECRYPT = 1'b1
    } dir_t;

    typedef struct packed {
        logic             load;
        logic             exp_wr;
        logic             keys_set;
        logic             rnd_en;
        logic [RK_AW-1:0] step;
        logic [RK_AW-1:0] rd_addr;
    } aes_cmd_t;

    typedef struct packed {
        logic keys_ready;
        dir_t direction;
        logic out_busy;
    } aes_sts_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    // Round constant byte for key expansion step n (n = 0..9)
    function automatic logic [7:0] rcon_byte(input logic [RK_AW-1:0] n);
        logic [7:0] r;
        case (n)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1b;
            4'd9:    r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte n of the block sits at bits [127-8n -: 8]; byte n is row n%4, column n/4
    function automatic logic [BLOCK_W-1:0] sub_bytes(input logic [BLOCK_W-1:0] s,
                                                     input logic inv);
        logic [BLOCK_W-1:0] o;
        o = '0;
        for (int n = 0; n < 16; n++) begin
            o[127-8*n -: 8] = inv ? INV_SBOX[s[127-8*n -: 8]] : SBOX[s[127-8*n -: 8]];
        end
        return o;
    endfunction

    function automatic logic [BLOCK_W-1:0] shift_rows(input logic [BLOCK_W-1:0] s,
                                                      input logic inv);
        logic [BLOCK_W-1:0] o;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    o[127-8*(4*((c+r)%4)+r) -: 8] = s[127-8*(4*c+r) -: 8];
                end else begin
                    o[127-8*(4*c+r) -: 8] = s[127-8*(4*((c+r)%4)+r) -: 8];
                end
            end
        end
        return o;
    endfunction

    function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] s,
                                                       input logic inv);
        logic [BLOCK_W-1:0] o;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]  = s[127-8*(4*c+k) -: 8];
                x2[k] = xtime(a[k]);
                x4[k] = xtime(x2[k]);
                x8[k] = xtime(x4[k]);
                m9[k] = x8[k] ^ a[k];
                mb[k] = x8[k] ^ x2[k] ^ a[k];
                md[k] = x8[k] ^ x4[k] ^ a[k];
                me[k] = x8[k] ^ x4[k] ^ x2[k];
            end
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    o[127-8*(4*c+r) -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
                end else begin
                    o[127-8*(4*c+r) -: 8] = x2[r] ^ x2[(r+1)%4] ^ a[(r+1)%4]
                                          ^ a[(r+2)%4] ^ a[(r+3)%4];
                end
            end
        end
        return o;
    endfunction

    // Next 128-bit round key from the current one
    function automatic logic [BLOCK_W-1:0] key_next(input logic [BLOCK_W-1:0] k,
                                                    input logic [7:0] rc);
        logic [31:0] w [4];
        logic [31:0] t;
        t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w[0] = k[127:96] ^ t;
        w[1] = k[95:64] ^ w[0];
        w[2] = k[63:32] ^ w[1];
        w[3] = k[31:0] ^ w[2];
        return {w[0], w[1], w[2], w[3]};
    endfunction

endpackage

### sv/aes128_block_cipher.sv
// After a key write, the next block first expands the round keys into the
//   round-key RAM; a new block is taken only when the previous rounds are done.
// Rounds run one per cycle through the shared round unit and one round-key RAM
//   read port; the last round stalls while the result register is occupied.
// Reset: aresetn synchronous, active low; clears keys, direction and key-ready.
// ----------------------------------------------------------------------------
// AES-128 block cipher
// ECB encrypt or decrypt of one 128-bit block per request.
// ----------------------------------------------------------------------------
module aes128_block_cipher (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aes_pkg::HALF_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [aes_pkg::HALF_W-1:0]    s_block_upper,
    input  logic [aes_pkg::HALF_W-1:0]    s_block_lower,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [aes_pkg::HALF_W-1:0]    m_result_upper,
    output logic [aes_pkg::HALF_W-1:0]    m_result_lower
);
    import aes_pkg::*;

    aes_cmd_t cmd;
    aes_sts_t sts;

    aes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    aes_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_block_upper  (s_block_upper),
        .s_block_lower  (s_block_lower),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_upper (m_result_upper),
        .m_result_lower (m_result_lower),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

### sv/aes_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 11
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/aes_ctrl.sv
// ----------------------------------------------------------------------------
// AES-128 controller
// Sequences key expansion and the eleven round-key steps of one block.
// ----------------------------------------------------------------------------
module aes_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  aes_pkg::aes_sts_t sts,
    output aes_pkg::aes_cmd_t cmd
);
    import aes_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ISSUE,
        ST_ROUND
    } state_t;

    state_t           state_reg, state_next;
    logic [RK_AW-1:0] cnt_reg, cnt_next;
    logic             last;

    // Round key row used at step n, in direction order
    function automatic logic [RK_AW-1:0] key_idx(input logic [RK_AW-1:0] n, input dir_t d);
        return (d == DIR_DECRYPT) ? LAST_ROUND - n : n;
    endfunction

    assign last = (cnt_reg == LAST_ROUND);

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.step     = cnt_reg;
        cmd.rd_addr  = key_idx('0, sts.direction);
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = sts.keys_ready ? ST_ROUND : ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                cmd.exp_wr = 1'b1;
                if (last) begin
                    cmd.keys_set = 1'b1;
                    state_next   = ST_ISSUE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ISSUE: begin
                cnt_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                // hold the last step while the result register is occupied
                cmd.rnd_en = !(last && sts.out_busy);
                if (last) begin
                    cmd.rd_addr = key_idx(cnt_reg, sts.direction);
                    if (cmd.rnd_en) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.rd_addr = key_idx(cnt_reg + 1'b1, sts.direction);
                    cnt_next    = cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && last && cmd.rnd_en) |=> state_reg == ST_IDLE)
        else $error("final round did not return to idle");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && !cmd.rnd_en) |=> (state_reg == ST_ROUND && $stable(cnt_reg)))
        else $error("stalled round advanced");

    a_expand_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_valid && !sts.keys_ready) |=> state_reg == ST_EXPAND)
        else $error("block accepted without key expansion");

endmodule

### sv/aes_dp.sv
// ----------------------------------------------------------------------------
// AES-128 datapath
// Configuration registers, key schedule, round-key RAM, round logic and the
// result register.
// ----------------------------------------------------------------------------
module aes_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [aes_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [aes_pkg::HALF_W-1:0]          cfg_data,
    input  logic [aes_pkg::HALF_W-1:0]          s_block_upper,
    input  logic [aes_pkg::HALF_W-1:0]          s_block_lower,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [aes_pkg::HALF_W-1:0]          m_result_upper,
    output logic [aes_pkg::HALF_W-1:0]          m_result_lower,
    input  aes_pkg::aes_cmd_t                   cmd,
    output aes_pkg::aes_sts_t                   sts
);
    import aes_pkg::*;

    logic [HALF_W-1:0]  key_upper_reg, key_lower_reg;
    dir_t               dir_reg;
    logic               keys_ready_reg;
    logic [BLOCK_W-1:0] kexp_reg;
    logic [BLOCK_W-1:0] state_reg, state_next;
    logic [BLOCK_W-1:0] result_reg;
    logic               m_valid_reg;
    logic [BLOCK_W-1:0] rk;
    logic [BLOCK_W-1:0] enc_t, dec_t;
    logic               is_last;

    // Configuration registers and key-ready flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_upper_reg  <= '0;
            key_lower_reg  <= '0;
            dir_reg        <= DIR_ENCRYPT;
            keys_ready_reg <= 1'b0;
        end else begin
            if (cmd.keys_set) begin
                keys_ready_reg <= 1'b1;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_KEY_UPPER: begin
                        key_upper_reg  <= cfg_data;
                        keys_ready_reg <= 1'b0;
                    end
                    CFG_KEY_LOWER: begin
                        key_lower_reg  <= cfg_data;
                        keys_ready_reg <= 1'b0;
                    end
                    CFG_DIRECTION: begin
                        dir_reg <= dir_t'(cfg_data[0]);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Key schedule: one round key per cycle
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kexp_reg <= {key_upper_reg, key_lower_reg};
        end else if (cmd.exp_wr) begin
            kexp_reg <= key_next(kexp_reg, rcon_byte(cmd.step));
        end
    end

    aes_ram #(
        .WIDTH (BLOCK_W),
        .DEPTH (RK_DEPTH)
    ) u_rk_ram (
        .aclk    (aclk),
        .wr_en   (cmd.exp_wr),
        .wr_addr (cmd.step),
        .wr_data (kexp_reg),
        .rd_addr (cmd.rd_addr),
        .rd_data (rk)
    );

    // Round logic
    assign is_last = (cmd.step == LAST_ROUND);

    always_comb begin
        enc_t = shift_rows(sub_bytes(state_reg, 1'b0), 1'b0);
        if (!is_last) begin
            enc_t = mix_columns(enc_t, 1'b0);
        end
        dec_t = sub_bytes(shift_rows(state_reg, 1'b1), 1'b1) ^ rk;
        if (!is_last) begin
            dec_t = mix_columns(dec_t, 1'b1);
        end
        if (cmd.step == '0) begin
            state_next = state_reg ^ rk;
        end else if (dir_reg == DIR_DECRYPT) begin
            state_next = dec_t;
        end else begin
            state_next = enc_t ^ rk;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            state_reg <= {s_block_upper, s_block_lower};
        end else if (cmd.rnd_en) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.rnd_en && is_last) begin
            result_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.rnd_en && is_last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_upper = result_reg[BLOCK_W-1:HALF_W];
    assign m_result_lower = result_reg[HALF_W-1:0];

    assign sts.keys_ready = keys_ready_reg;
    assign sts.direction  = dir_reg;
    assign sts.out_busy   = m_valid_reg && !m_ready;

endmodule

### sim/aes128_block_cipher_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 block cipher checker
// Tracks the key and direction registers, predicts each cipher result from
// every accepted request and compares results in order on the output side.
// ----------------------------------------------------------------------------
module aes128_block_cipher_chk (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aes_pkg::HALF_W-1:0]    cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [aes_pkg::HALF_W-1:0]    s_block_upper,
    input  logic [aes_pkg::HALF_W-1:0]    s_block_lower,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [aes_pkg::HALF_W-1:0]    m_result_upper,
    input  logic [aes_pkg::HALF_W-1:0]    m_result_lower,
    output int                            fail_count,
    output int                            pending_count
);
    import aes_pkg::*;

    logic [63:0]  key_hi;
    logic [63:0]  key_lo;
    dir_t         dir_q;
    logic         sched_valid;
    logic [31:0]  sched [44];
    logic [127:0] expected_blocks [$];

    localparam logic [7:0] RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                         8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    // Fill the round-key schedule from the current key
    task automatic build_schedule();
        logic [31:0] t;
        {sched[0], sched[1], sched[2], sched[3]} = {key_hi, key_lo};
        for (int n = 4; n < 44; n++) begin
            t = sched[n-1];
            if (n % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]}
                  ^ {RCON[n/4-1], 24'h0};
            end
            sched[n] = sched[n-4] ^ t;
        end
        sched_valid = 1'b1;
    endtask

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [127:0] with_round_key(input logic [127:0] s, input int rnd);
        return s ^ {sched[4*rnd], sched[4*rnd+1], sched[4*rnd+2], sched[4*rnd+3]};
    endfunction

    // One round layer: substitute bytes and shift rows, either direction
    function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        int src;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? 4*((c + 4 - r) % 4) + r : 4*((c + r) % 4) + r;
                o[127-8*(4*c+r) -: 8] = inv ? INV_SBOX[s[127-8*src -: 8]]
                                            : SBOX[s[127-8*src -: 8]];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        logic [7:0] m [4];
        logic [7:0] acc;
        if (inv) begin
            m = '{8'd14, 8'd11, 8'd13, 8'd9};
        end else begin
            m = '{8'd2, 8'd3, 8'd1, 8'd1};
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = '0;
                for (int k = 0; k < 4; k++)
                    acc ^= gmul(s[127-8*(4*c+k) -: 8], m[(k + 4 - r) % 4]);
                o[127-8*(4*c+r) -: 8] = acc;
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] cipher_block(input logic [127:0] blk, input dir_t d);
        logic [127:0] s;
        if (d == DIR_ENCRYPT) begin
            s = with_round_key(blk, 0);
            for (int rnd = 1; rnd < 10; rnd++)
                s = with_round_key(mix(sub_shift(s, 1'b0), 1'b0), rnd);
            s = with_round_key(sub_shift(s, 1'b0), 10);
        end else begin
            s = with_round_key(blk, 10);
            for (int rnd = 9; rnd > 0; rnd--)
                s = mix(with_round_key(sub_shift(s, 1'b1), rnd), 1'b1);
            s = with_round_key(sub_shift(s, 1'b1), 0);
        end
        return s;
    endfunction

    // Track registers, predict on request, compare on result
    always @(posedge aclk) begin
        logic [127:0] want;
        logic [127:0] got;
        if (!aresetn) begin
            key_hi      = '0;
            key_lo      = '0;
            dir_q       = DIR_ENCRYPT;
            sched_valid = 1'b0;
            fail_count  = 0;
            expected_blocks.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_KEY_UPPER: begin
                        key_hi = cfg_data;
                        sched_valid = 1'b0;
                    end
                    CFG_KEY_LOWER: begin
                        key_lo = cfg_data;
                        sched_valid = 1'b0;
                    end
                    CFG_DIRECTION: dir_q = dir_t'(cfg_data[0]);
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (!sched_valid) build_schedule();
                expected_blocks.push_back(cipher_block({s_block_upper, s_block_lower}, dir_q));
            end
            if (m_valid && m_ready) begin
                got = {m_result_upper, m_result_lower};
                if (expected_blocks.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", got);
                end else begin
                    want = expected_blocks.pop_front();
                    if (want[127:64] !== got[127:64] || want[63:0] !== got[63:0]) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: upper exp %h got %h, lower exp %h got %h",
                                     want[127:64], got[127:64], want[63:0], got[63:0]);
                    end
                end
            end
        end
        pending_count = expected_blocks.size();
    end

endmodule

### sim/aes128_block_cipher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Drives directed and random blocks under several keys and both directions,
// with random request and result stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module aes128_block_cipher_tb;
    import aes_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 600000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_block_upper;
    logic [63:0] s_block_lower;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_result_upper;
    logic [63:0] m_result_lower;
    int          fail_count;
    int          pending_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        req_taken;

    aes128_block_cipher u_dut (.*);

    aes128_block_cipher_chk u_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Note request acceptance and bound the run
    always @(posedge aclk) begin
        req_taken <= s_valid && s_ready;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stall the result side at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Write one register, then drop the enable
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Drain outstanding results before touching registers
    task automatic wait_drained();
        while (pending_count != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    // Hold the request until accepted, then drop valid
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid       <= 1'b1;
        s_block_upper <= hi;
        s_block_lower <= lo;
        do @(negedge aclk); while (!req_taken);
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        cycle_count   = 0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_KEY_UPPER;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_block_upper = '0;
        s_block_lower = '0;
        m_ready       = 1'b0;
        req_taken     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Blocks under the reset key, before any register write
        send_block('0, '0);
        send_block('1, '1);
        wait_drained();

        // Standard key, encrypt then decrypt the known vector
        write_reg(CFG_KEY_UPPER, 64'h0001020304050607);
        write_reg(CFG_KEY_LOWER, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(64'h8000000000000000, 64'h0000000000000001);
        wait_drained();
        write_reg(CFG_DIRECTION, 64'h1);
        send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block('0, '1);
        wait_drained();

        // Upper data bits on direction are dropped; spare index ignored
        write_reg(CFG_DIRECTION, 64'hffff_ffff_ffff_fffe);
        write_reg(CFG_INDEX_SPARE, '1);
        send_block('1, '0);
        wait_drained();

        // All-ones key both ways; direction change keeps the schedule
        write_reg(CFG_KEY_UPPER, '1);
        write_reg(CFG_KEY_LOWER, '1);
        send_block('0, '0);
        send_block('1, '1);
        wait_drained();
        write_reg(CFG_DIRECTION, '1);
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        wait_drained();

        // Random keys and blocks across three stall patterns
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 38 : 0;
            for (int seg = 0; seg < 8; seg++) begin
                wait_drained();
                if ($urandom_range(3) != 0) begin
                    write_reg(CFG_KEY_UPPER, pick_word());
                    write_reg(CFG_KEY_LOWER, pick_word());
                end
                write_reg(CFG_DIRECTION, {$urandom, $urandom});
                for (int n = 0; n < 25; n++)
                    send_block(pick_word(), pick_word());
            end
        end

        while (pending_count != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
